// File: rtl/core/datetime_text_parser_defines.svh
// ---------------------------------------------------------------------------
// Datetime text parser assertion macros
// Shared property forms for the parser's concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef DATETIME_TEXT_PARSER_DEFINES_SVH
`define DATETIME_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("datetime parser assertion failed");

// Next-cycle implication, checked outside reset.
`define DTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("datetime parser assertion failed");

`endif

// File: rtl/core/dtp_pkg.sv
// ---------------------------------------------------------------------------
// Datetime text parser package
// Character codes, field layout, status type and the power-of-ten table.
// ---------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  localparam int NUM_FIELDS   = 7;
  localparam int NANOS_FIELD  = 6;
  localparam int FIELD_W      = 32;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 4;
  localparam int SCALE_W      = 30;

  localparam logic [IDX_W-1:0] SEP_LAST_IDX = 3'd5;
  localparam logic [IDX_W-1:0] DOT_LAST_IDX = 3'd6;
  localparam logic [CNT_W-1:0] NANOS_DIGITS = 4'd9;
  localparam logic [CNT_W-1:0] FRAC_CNT_MAX = 4'd10;

  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] field_arr_t;

  typedef struct packed {
    logic             error;
    logic             dot_seen;
    logic [CNT_W-1:0] frac_cnt;
  } dtp_status_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [SCALE_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtp_char_unit.sv
// ---------------------------------------------------------------------------
// Datetime parser character unit
// Holds the per-string parse state and applies one character per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module dtp_char_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         char_code,
  input  wire logic               is_last,
  output dtp_pkg::field_arr_t     fields_nxt,
  output dtp_pkg::dtp_status_t    status_nxt
);
  import dtp_pkg::*;

  field_arr_t       fields_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             dot_r, dot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic             do_count;
  logic [FIELD_W-1:0] cur;

  assign cur = fields_r[idx_r];

  always_comb begin
    fields_nxt = fields_r;
    idx_nxt    = idx_r;
    dot_nxt    = dot_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    do_count   = 1'b0;
    if (!err_r) begin
      case (char_code) inside
        CHAR_DASH, CHAR_SPACE, CHAR_COLON: begin
          if (idx_r >= SEP_LAST_IDX) begin
            err_nxt = 1'b1;
          end else begin
            idx_nxt  = idx_r + 3'd1;
            do_count = dot_r;
          end
        end
        CHAR_DOT: begin
          if (idx_r >= DOT_LAST_IDX) begin
            err_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 3'd1;
            dot_nxt = 1'b1;
            cnt_nxt = '0;
          end
        end
        [CHAR_ZERO:CHAR_NINE]: begin
          fields_nxt[idx_r] = (cur << 3) + (cur << 1)
                            + FIELD_W'(char_code - CHAR_ZERO);
          do_count = dot_r;
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
    if (do_count && (cnt_r < FRAC_CNT_MAX)) begin
      cnt_nxt = cnt_r + 4'd1;
    end
  end

  assign status_nxt = '{error: err_nxt, dot_seen: dot_nxt, frac_cnt: cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= '0;
      idx_r    <= '0;
      dot_r    <= 1'b0;
      cnt_r    <= '0;
      err_r    <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        fields_r <= '0;
        idx_r    <= '0;
        dot_r    <= 1'b0;
        cnt_r    <= '0;
        err_r    <= 1'b0;
      end else begin
        fields_r <= fields_nxt;
        idx_r    <= idx_nxt;
        dot_r    <= dot_nxt;
        cnt_r    <= cnt_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/datetime_text_parser.sv
// Takes one character per cycle while in_stall is low; at the transfer of a
// string's last character its fields are captured in the snapshot register.
// The fraction scaling multiplier sits in its own stage between the snapshot
// register and the result register.
// Synchronous active-low reset clears the parse state and both stage valids.
// ---------------------------------------------------------------------------
// Datetime text parser
// Parses a datetime string into seven numeric fields and an error flag.
// ---------------------------------------------------------------------------
`default_nettype none

module datetime_text_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_year_value,
  output logic [31:0]      out_month_value,
  output logic [31:0]      out_day_value,
  output logic [31:0]      out_hour_value,
  output logic [31:0]      out_minute_value,
  output logic [31:0]      out_second_value,
  output logic [31:0]      out_nanos_value,
  output logic             out_parse_error
);
  import dtp_pkg::*;

  field_arr_t          fields_nxt;
  dtp_status_t         status_nxt;
  logic                in_take;
  logic                out_free;
  logic                s1_adv;

  logic                s1_v_r;
  field_arr_t          s1_fields_r;
  logic                s1_err_r;
  logic [SCALE_W-1:0]  s1_scale_r;
  logic [SCALE_W-1:0]  scale_nxt;
  logic [FIELD_W-1:0]  nanos_prod;
  field_arr_t          res_fields;

  logic                out_valid_r;
  field_arr_t          out_fields_r;
  logic                out_err_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  dtp_char_unit u_char (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_take),
    .char_code  (in_char_code),
    .is_last    (in_is_last),
    .fields_nxt (fields_nxt),
    .status_nxt (status_nxt)
  );

  always_comb begin
    if (status_nxt.dot_seen && (status_nxt.frac_cnt < NANOS_DIGITS)) begin
      scale_nxt = pow10(NANOS_DIGITS - status_nxt.frac_cnt);
    end else begin
      scale_nxt = pow10('0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take && in_is_last) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_is_last) begin
      s1_fields_r <= fields_nxt;
      s1_err_r    <= status_nxt.error;
      s1_scale_r  <= scale_nxt;
    end
  end

  assign nanos_prod = s1_fields_r[NANOS_FIELD] * FIELD_W'(s1_scale_r);

  always_comb begin
    res_fields              = s1_fields_r;
    res_fields[NANOS_FIELD] = nanos_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_err_r <= s1_err_r;
      if (s1_err_r) begin
        out_fields_r <= '0;
      end else begin
        out_fields_r <= res_fields;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year_value   = out_fields_r[0];
  assign out_month_value  = out_fields_r[1];
  assign out_day_value    = out_fields_r[2];
  assign out_hour_value   = out_fields_r[3];
  assign out_minute_value = out_fields_r[4];
  assign out_second_value = out_fields_r[5];
  assign out_nanos_value  = out_fields_r[NANOS_FIELD];
  assign out_parse_error  = out_err_r;

`include "datetime_text_parser_defines.svh"

  `DTP_ASSERT_NEXT(a_last_fills_snapshot, in_take && in_is_last, s1_v_r)
  `DTP_ASSERT_NEXT(a_snapshot_reaches_out, s1_adv, out_valid_r)
  `DTP_ASSERT_NEXT(a_blocked_snapshot_holds, s1_v_r && !out_free, s1_v_r)
  `DTP_ASSERT_IMPLY(a_error_clears_fields, out_valid_r && out_err_r, out_fields_r == '0)

endmodule

`default_nettype wire

// File: tb/sv/datetime_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// Datetime parser scoreboard
// Tracks the parse of each string from its accepted characters, and compares
// the parsed fields and error flag of every result transfer with the oldest expected one.
// ---------------------------------------------------------------------------
package datetime_scoreboard_pkg;

  import dtp_pkg::*;

  typedef struct packed {
    field_arr_t values;
    logic       parse_error;
  } datetime_result_t;

  class datetime_scoreboard;

    logic [FIELD_W-1:0] fields [NUM_FIELDS];
    int unsigned        field_idx;
    bit                 dot_seen;
    bit                 err_seen;
    int unsigned        frac_cnt;
    datetime_result_t   pending_results [$];
    int unsigned        mismatches;
    string              field_names [NUM_FIELDS];

    function new();
      field_names = '{"year", "month", "day", "hour", "minute", "second", "nanos"};
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      foreach (fields[k]) fields[k] = '0;
      field_idx = 0;
      dot_seen = 1'b0;
      err_seen = 1'b0;
      frac_cnt = 0;
    endfunction

    function void take_char(logic [7:0] c);
      bit counted;
      counted = dot_seen;
      if (c == CHAR_DASH || c == CHAR_SPACE || c == CHAR_COLON) begin
        if (field_idx >= SEP_LAST_IDX) begin
          err_seen = 1'b1;
          return;
        end
        field_idx++;
      end else if (c == CHAR_DOT) begin
        if (field_idx >= DOT_LAST_IDX) begin
          err_seen = 1'b1;
          return;
        end
        field_idx++;
        dot_seen = 1'b1;
        frac_cnt = 0;
        counted = 1'b0;
      end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
        err_seen = 1'b1;
        return;
      end else begin
        fields[field_idx] = fields[field_idx] * 32'd10 + 32'(c - CHAR_ZERO);
      end
      if (counted && frac_cnt < FRAC_CNT_MAX) frac_cnt++;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      datetime_result_t exp_res;
      if (!err_seen) take_char(c);
      if (!last) return;
      exp_res = '0;
      if (err_seen) begin
        exp_res.parse_error = 1'b1;
      end else begin
        if (dot_seen) begin
          for (int unsigned k = frac_cnt; k < NANOS_DIGITS; k++) begin
            fields[NANOS_FIELD] = fields[NANOS_FIELD] * 32'd10;
          end
        end
        foreach (fields[k]) exp_res.values[k] = fields[k];
      end
      pending_results.push_back(exp_res);
      clear_parse();
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] got_val);
      if (mismatches < 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, exp_val, got_val);
      end
      mismatches++;
    endfunction

    function void check_result(datetime_result_t got);
      datetime_result_t exp_res;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("result transfer with no string pending");
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      for (int k = 0; k < NUM_FIELDS; k++) begin
        if (got.values[k] !== exp_res.values[k]) begin
          report(field_names[k], exp_res.values[k], got.values[k]);
        end
      end
      if (got.parse_error !== exp_res.parse_error) begin
        report("parse_error", 32'(exp_res.parse_error), 32'(got.parse_error));
      end
    endfunction

    function bit failed();
      return mismatches != 0 || pending_results.size() != 0;
    endfunction

  endclass

endpackage

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Datetime text parser testbench
// Feeds directed and random datetime strings one character per transfer,
// with random sender gaps and receiver stalls, and checks every result.
// ---------------------------------------------------------------------------
module tb_top;

  import dtp_pkg::*;
  import datetime_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_year_value;
  logic [31:0] out_month_value;
  logic [31:0] out_day_value;
  logic [31:0] out_hour_value;
  logic [31:0] out_minute_value;
  logic [31:0] out_second_value;
  logic [31:0] out_nanos_value;
  logic        out_parse_error;

  datetime_scoreboard sb = new();
  logic [7:0]         text_q [$];
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        chars_sent = 0;

  datetime_text_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_value   (out_year_value),
    .out_month_value  (out_month_value),
    .out_day_value    (out_day_value),
    .out_hour_value   (out_hour_value),
    .out_minute_value (out_minute_value),
    .out_second_value (out_second_value),
    .out_nanos_value  (out_nanos_value),
    .out_parse_error  (out_parse_error)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    datetime_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_char_code, in_is_last);
      if (out_valid && !out_stall) begin
        got.values[0] = out_year_value;
        got.values[1] = out_month_value;
        got.values[2] = out_day_value;
        got.values[3] = out_hour_value;
        got.values[4] = out_minute_value;
        got.values[5] = out_second_value;
        got.values[6] = out_nanos_value;
        got.parse_error = out_parse_error;
        sb.check_result(got);
      end
    end
  end

  task automatic send_text();
    int unsigned k;
    for (k = 0; k < text_q.size(); k++) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_char_code <= text_q[k];
      in_is_last <= (k == text_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      chars_sent++;
    end
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(2))
      0:       return CHAR_DASH;
      1:       return CHAR_SPACE;
      default: return CHAR_COLON;
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(5, 12);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic push_digits(input int unsigned n);
    repeat (n) text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic make_datetime();
    int unsigned nfields;
    text_q.delete();
    nfields = $urandom_range(1, 6);
    for (int unsigned k = 0; k < nfields; k++) begin
      if (k != 0) text_q.push_back(pick_separator());
      push_digits(pick_width());
    end
    if ($urandom_range(3) != 0) begin
      text_q.push_back(CHAR_DOT);
      push_digits($urandom_range(0, 12));
    end
    if (text_q.size() == 0) push_digits(1);
  endtask

  task automatic make_soup();
    int unsigned len;
    text_q.delete();
    len = $urandom_range(1, 16);
    repeat (len) begin
      case ($urandom_range(5))
        0:       text_q.push_back(pick_separator());
        1:       text_q.push_back(CHAR_DOT);
        default: push_digits(1);
      endcase
    end
  endtask

  task automatic make_noise();
    int unsigned len;
    text_q.delete();
    len = $urandom_range(1, 6);
    repeat (len) text_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_random_string();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      make_datetime();
    end else if (pick < 75) begin
      make_datetime();
      text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 90) begin
      make_soup();
    end else begin
      make_noise();
    end
    send_text();
  endtask

  task automatic send_directed();
    text_q = '{8'hff, CHAR_NINE};
    send_text();
    text_q = '{8'h00};
    send_text();
    text_q = '{CHAR_DOT};
    send_text();
    text_q = '{CHAR_DASH, CHAR_DASH, CHAR_SPACE, CHAR_COLON, CHAR_DASH, CHAR_COLON};
    send_text();
    text_q = '{"1", CHAR_COLON, "2", CHAR_SPACE, "3", CHAR_DASH, "4", CHAR_COLON, "5",
               CHAR_DOT, "6", CHAR_DOT};
    send_text();
    text_q = '{CHAR_NINE, CHAR_DOT, "5"};
    send_text();
  endtask

  initial begin
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    phase_idle = '{0, 76, 0, 33};
    phase_stall = '{0, 0, 76, 33};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      while (chars_sent < (p + 1) * 350) send_random_string();
    end
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failed()) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dtp_pkg.sv
rtl/core/dtp_char_unit.sv
rtl/core/datetime_text_parser.sv
tb/sv/datetime_scoreboard_pkg.sv
tb/sv/tb_top.sv
